// ===== hdl/pump_shift_register_chain_driver_unit_macros.svh =====
// pump_shift_register_chain_driver_unit_macros.svh
// assertion macros used by the pump chain driver back end; no dependencies
`ifndef PUMP_SHIFT_REGISTER_CHAIN_DRIVER_UNIT_MACROS_SVH
`define PUMP_SHIFT_REGISTER_CHAIN_DRIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PUMPSR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pump chain driver assertion failed");

// next-cycle implication, disabled during reset
`define PUMPSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pump chain driver assertion failed");

`endif

// ===== hdl/pumpsr_pkg.sv =====
// pumpsr_pkg.sv
// types and constants of the pump shift-register chain driver; no dependencies
`default_nettype none

package pumpsr_pkg;

   // chain size limits
   localparam int DEFAULT_MAX_MODULES = 8;
   localparam int COUNT_W             = 4;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

   // byte layout: four 2-bit motor fields per module byte
   localparam int          SLOTS_PER_MODULE = 4;
   localparam logic [1:0]  SLOT_MASK        = 2'b11;
   localparam logic [7:0]  BYTE_ONES        = 8'b11111111;
   localparam logic [2:0]  MSB_BIT          = 3'd7;

   // command codes
   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_STOP  = 2'd1,
      OP_OPEN  = 2'd2,
      OP_SHIFT = 2'd3
   } opcode_type;

   // classified command word handed from front to back
   typedef struct packed {
      opcode_type op;
      logic [2:0] module_num;
      logic [1:0] slot;
      logic [1:0] code;
      logic       in_range;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/pumpsr_front.sv =====
// pumpsr_front.sv
// accepts request words, classifies them and holds them in a two-entry queue
// depends on pumpsr_pkg
`default_nettype none

module pumpsr_front
   import pumpsr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] modules_in_use,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [4:0]         req_motor_index,
   input  wire logic [1:0]         req_motor_status,
   output logic                    cmd_valid,
   output cmd_type                 cmd,
   input  wire logic               cmd_ready
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cls;
   logic       push, pop;

   // classify: module number, slot, and whether the module is in the chain
   always_comb begin
      cls.op         = opcode_type'(req_opcode);
      cls.module_num = req_motor_index[4:2];
      cls.slot       = req_motor_index[1:0];
      cls.code       = req_motor_status;
      cls.in_range   = ({1'b0, req_motor_index[4:2]} < modules_in_use);
   end

   // queue handshake
   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pumpsr_back.sv =====
// pumpsr_back.sv
// module byte store, shift sequencer and output register of the chain driver
// depends on pumpsr_pkg and the assertion macro header
`default_nettype none
`include "pump_shift_register_chain_driver_unit_macros.svh"

module pumpsr_back
   import pumpsr_pkg::*;
#(
   parameter int MAX_MODULES = DEFAULT_MAX_MODULES
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] modules_in_use,
   input  wire logic               cmd_valid,
   input  wire cmd_type            cmd,
   output logic                    cmd_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_serial_bit,
   output logic                    rsp_bit_valid,
   output logic                    rsp_last,
   output logic                    rsp_all_stopped
);

   localparam int MOD_W = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_SHIFT
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       store_ff [MAX_MODULES];
   logic [7:0]       store_in [MAX_MODULES];
   logic [MOD_W-1:0] mod_ff, mod_in;
   logic [2:0]       bit_ff, bit_in;
   logic             stopped_ff, stopped_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_serial_bit_ff, rsp_serial_bit_in;
   logic             rsp_bit_valid_ff, rsp_bit_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_all_stopped_ff, rsp_all_stopped_in;
   logic             out_free;
   logic             take;
   logic             all_zero_in;
   logic             final_bit;
   logic [2:0]       field_shift;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd_ready   = (state_ff == ST_IDLE) && out_free;
   assign take        = cmd_valid && cmd_ready;
   assign field_shift = {cmd.slot, 1'b0};
   assign final_bit   = (mod_ff == '0) && (bit_ff == 3'd0);

   // next store contents for the command being taken
   always_comb begin
      for (int m = 0; m < MAX_MODULES; m++) begin
         store_in[m] = store_ff[m];
      end
      if (take) begin
         case (cmd.op)
            OP_SET: begin
               for (int m = 0; m < MAX_MODULES; m++) begin
                  if (cmd.in_range && (3'(m) == cmd.module_num)) begin
                     store_in[m] = (store_ff[m] & ~(8'(SLOT_MASK) << field_shift))
                                 | (8'(cmd.code) << field_shift);
                  end
               end
            end
            OP_STOP: begin
               for (int m = 0; m < MAX_MODULES; m++) begin
                  if (4'(m) < modules_in_use) begin
                     store_in[m] = 8'd0;
                  end
               end
            end
            OP_OPEN: begin
               for (int m = 0; m < MAX_MODULES; m++) begin
                  if (4'(m) < modules_in_use) begin
                     store_in[m] = BYTE_ONES;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // zero check over the bytes in use after the command
   always_comb begin
      all_zero_in = 1'b1;
      for (int m = 0; m < MAX_MODULES; m++) begin
         if ((4'(m) < modules_in_use) && (store_in[m] != 8'd0)) begin
            all_zero_in = 1'b0;
         end
      end
   end

   // sequencer and output register next values
   always_comb begin
      state_in           = state_ff;
      mod_in             = mod_ff;
      bit_in             = bit_ff;
      stopped_in         = stopped_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_serial_bit_in  = rsp_serial_bit_ff;
      rsp_bit_valid_in   = rsp_bit_valid_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_all_stopped_in = rsp_all_stopped_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd.op == OP_SET) begin
                  rsp_valid_in       = 1'b1;
                  rsp_serial_bit_in  = 1'b0;
                  rsp_bit_valid_in   = 1'b0;
                  rsp_last_in        = 1'b0;
                  rsp_all_stopped_in = all_zero_in;
               end else begin
                  state_in   = ST_SHIFT;
                  mod_in     = MOD_W'(modules_in_use - 4'd1);
                  bit_in     = MSB_BIT;
                  stopped_in = all_zero_in;
               end
            end
         end
         ST_SHIFT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_serial_bit_in  = store_ff[mod_ff][bit_ff];
               rsp_bit_valid_in   = 1'b1;
               rsp_last_in        = final_bit;
               rsp_all_stopped_in = stopped_ff;
               bit_in             = bit_ff - 3'd1;
               if (bit_ff == 3'd0) begin
                  mod_in = mod_ff - MOD_W'(1);
               end
               if (final_bit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, store and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < MAX_MODULES; m++) begin
            store_ff[m] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int m = 0; m < MAX_MODULES; m++) begin
            store_ff[m] <= store_in[m];
         end
      end
      mod_ff             <= mod_in;
      bit_ff             <= bit_in;
      stopped_ff         <= stopped_in;
      rsp_serial_bit_ff  <= rsp_serial_bit_in;
      rsp_bit_valid_ff   <= rsp_bit_valid_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_all_stopped_ff <= rsp_all_stopped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_serial_bit  = rsp_serial_bit_ff;
   assign rsp_bit_valid   = rsp_bit_valid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_all_stopped = rsp_all_stopped_ff;

   // checks
   `PUMPSR_ASSERT_IMPL(a_last_is_bit, clock, reset,
      rsp_valid_ff && rsp_last_ff, rsp_bit_valid_ff)
   `PUMPSR_ASSERT_IMPL(a_status_bit_low, clock, reset,
      rsp_valid_ff && !rsp_bit_valid_ff, !rsp_serial_bit_ff)
   `PUMPSR_ASSERT_IMPL(a_one_bit_not_stopped, clock, reset,
      rsp_valid_ff && rsp_bit_valid_ff && rsp_serial_bit_ff, !rsp_all_stopped_ff)
   `PUMPSR_ASSERT_IMPL(a_no_pop_while_shifting, clock, reset,
      state_ff == ST_SHIFT, !cmd_ready)
   `PUMPSR_ASSERT_NEXT(a_final_bit_ends_run, clock, reset,
      (state_ff == ST_SHIFT) && out_free && final_bit, state_ff == ST_IDLE)

endmodule

`default_nettype wire

// ===== hdl/pump_shift_register_chain_driver_unit.sv =====
// Pump shift-register chain driver.
// Request channel (req_valid/req_ready) takes one command word: opcode,
// motor_index and motor_status. Response channel (rsp_valid/rsp_ready)
// returns result words: serial_bit, bit_valid, last and all_stopped.
// csr_wr_en with csr_wr_data sets the module count (0 acts as 1, values
// above MAX_MODULES act as MAX_MODULES); write it only while the block idles.
// A set-status command gives one status word through the output register.
// Stop all, open all and shift out first load the sequencer, then give 8
// words per module in use, one per cycle while the receiver is ready;
// the words come from the one-bit-per-cycle serializer in the back end.
// A two-word queue sits between the front end and the back end, so up to
// two further commands are taken while a shift is running.
// Reset clears all module bytes, the queue and the output register and sets
// the module count to 1. A stalled receiver holds the current word in the
// output register and the serializer waits; nothing is dropped.
// depends on pumpsr_pkg, pumpsr_front and pumpsr_back
`default_nettype none

module pump_shift_register_chain_driver_unit
   import pumpsr_pkg::*;
#(
   parameter int MAX_MODULES = DEFAULT_MAX_MODULES
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [4:0]         req_motor_index,
   input  wire logic [1:0]         req_motor_status,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_serial_bit,
   output logic                    rsp_bit_valid,
   output logic                    rsp_last,
   output logic                    rsp_all_stopped
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] modules_in_use;
   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd;

   // module count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // clamp the count to the chain length actually built; a count of zero acts as one
   always_comb begin
      modules_in_use = count_ff;
      if (count_ff == '0) begin
         modules_in_use = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_MODULES)) begin
         modules_in_use = COUNT_W'(MAX_MODULES);
      end
   end

   // accept and classify
   pumpsr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .modules_in_use   (modules_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_motor_index  (req_motor_index),
      .req_motor_status (req_motor_status),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_ready        (cmd_ready)
   );

   // store and serialize
   pumpsr_back #(
      .MAX_MODULES (MAX_MODULES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .modules_in_use  (modules_in_use),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_ready       (cmd_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_bit_valid   (rsp_bit_valid),
      .rsp_last        (rsp_last),
      .rsp_all_stopped (rsp_all_stopped)
   );

endmodule

`default_nettype wire

// ===== sim/pump_chain_tb_pkg.sv =====
// pump_chain_tb_pkg.sv
// scoreboard class for the pump chain driver bench: it tracks the module bytes and
// checks each response word; depends on pumpsr_pkg
package pump_chain_tb_pkg;
   import pumpsr_pkg::*;

   // one response word as seen on the rsp_ ports
   typedef struct packed {
      logic serial_bit;
      logic bit_valid;
      logic last;
      logic all_stopped;
   } chain_word_type;

   class pump_chain_tracker;
      logic [7:0]         ctrl_bytes [DEFAULT_MAX_MODULES];
      logic [COUNT_W-1:0] count_reg;
      chain_word_type     words_due [$];
      int                 errors;

      function new();
         foreach (ctrl_bytes[i]) ctrl_bytes[i] = 8'h00;
         count_reg = COUNT_RESET;
         errors    = 0;
      endfunction

      function void set_count(logic [COUNT_W-1:0] value);
         count_reg = value;
      endfunction

      // a count of zero acts as one, a count above the chain length acts as the full chain
      function int modules_active();
         int n;
         n = int'(count_reg);
         if (n < 1) n = 1;
         if (n > DEFAULT_MAX_MODULES) n = DEFAULT_MAX_MODULES;
         return n;
      endfunction

      // only the modules in use count
      function logic chain_clear(int n);
         for (int m = 0; m < n; m++)
            if (ctrl_bytes[m] != 8'h00) return 1'b0;
         return 1'b1;
      endfunction

      // update the bytes for one accepted command and queue the words it produces
      function void note_command(opcode_type op, logic [4:0] idx, logic [1:0] code);
         int             n;
         int             mod;
         int             shift;
         int             m;
         int             b;
         logic [7:0]     mask;
         logic           stopped;
         chain_word_type w;
         n = modules_active();
         if (op == OP_SET) begin
            mod   = int'(idx) / SLOTS_PER_MODULE;
            shift = (int'(idx) % SLOTS_PER_MODULE) * 2;
            // a motor past the chain leaves every byte alone
            if (mod < n) begin
               mask            = {6'b0, SLOT_MASK} << shift;
               ctrl_bytes[mod] = (ctrl_bytes[mod] & ~mask) | (({6'b0, code} << shift) & mask);
            end
            w.serial_bit  = 1'b0;
            w.bit_valid   = 1'b0;
            w.last        = 1'b0;
            w.all_stopped = chain_clear(n);
            words_due.push_back(w);
         end else begin
            // bytes past the count keep their contents
            if (op == OP_STOP)
               for (m = 0; m < n; m++) ctrl_bytes[m] = 8'h00;
            else if (op == OP_OPEN)
               for (m = 0; m < n; m++) ctrl_bytes[m] = BYTE_ONES;
            stopped = chain_clear(n);
            // highest module first, msb first within each byte
            for (m = n - 1; m >= 0; m--) begin
               for (b = int'(MSB_BIT); b >= 0; b--) begin
                  w.serial_bit  = ctrl_bytes[m][b];
                  w.bit_valid   = 1'b1;
                  w.last        = (m == 0 && b == 0);
                  w.all_stopped = stopped;
                  words_due.push_back(w);
               end
            end
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // compare one accepted response word with the oldest one due
      task check_word(chain_word_type got);
         chain_word_type want;
         if (words_due.size() == 0) begin
            report($sformatf("response word %b with nothing due", got));
         end else begin
            want = words_due.pop_front();
            if (got.serial_bit !== want.serial_bit)
               report($sformatf("serial_bit %b, wanted %b", got.serial_bit, want.serial_bit));
            if (got.bit_valid !== want.bit_valid)
               report($sformatf("bit_valid %b, wanted %b", got.bit_valid, want.bit_valid));
            if (got.last !== want.last)
               report($sformatf("last %b, wanted %b", got.last, want.last));
            if (got.all_stopped !== want.all_stopped)
               report($sformatf("all_stopped %b, wanted %b", got.all_stopped,
                                want.all_stopped));
         end
      endtask
   endclass

endpackage

// ===== sim/tb_top.sv =====
// tb_top.sv
// bench top for the pump chain driver: directed and random commands with random idling
// on both channels; depends on pumpsr_pkg, pump_chain_tb_pkg and the driver rtl
module tb_top;
   import pumpsr_pkg::*;
   import pump_chain_tb_pkg::*;

   localparam int STALL_LIMIT     = 1000;
   localparam int ITEMS_PER_PHASE = 41;
   localparam int END_CYCLES      = 40;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_wr_en        = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data      = '0;
   logic               req_valid        = 1'b0;
   logic [1:0]         req_opcode       = 2'b00;
   logic [4:0]         req_motor_index  = 5'd0;
   logic [1:0]         req_motor_status = 2'b00;
   logic               rsp_ready        = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_serial_bit;
   logic               rsp_bit_valid;
   logic               rsp_last;
   logic               rsp_all_stopped;

   bit                 calm        = 1'b0;
   int                 idle_cycles = 0;
   pump_chain_tracker  tracker     = new();

   pump_shift_register_chain_driver_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_motor_index  (req_motor_index),
      .req_motor_status (req_motor_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_serial_bit   (rsp_serial_bit),
      .rsp_bit_valid    (rsp_bit_valid),
      .rsp_last         (rsp_last),
      .rsp_all_stopped  (rsp_all_stopped)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // mostly short gaps, now and then a long one; none while calm
   function int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // present one command word and hold it until taken
   task send_word(opcode_type op, logic [4:0] idx, logic [1:0] code);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_motor_index  <= idx;
      req_motor_status <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_command(op, idx, code);
   endtask

   // hold off the sender until every due word has come back
   task wait_chain_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.words_due.size() != 0);
   endtask

   task write_count(logic [COUNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_count(value);
   endtask

   // mostly motor writes inside the chain, mixed with whole-chain commands
   task random_word();
      int         n;
      int         r;
      logic [4:0] idx;
      logic [1:0] code;
      n = tracker.modules_active();
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) idx = 5'($urandom_range(0, 4 * n - 1));
      else idx = 5'($urandom_range(0, 31));
      code = 2'($urandom_range(0, 3));
      if (r < 55) send_word(OP_SET, idx, code);
      else if (r < 70) send_word(OP_SHIFT, idx, code);
      else if (r < 85) send_word(OP_STOP, idx, code);
      else send_word(OP_OPEN, idx, code);
   endtask

   // receiver stalls at random
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_word(chain_word_type'({rsp_serial_bit, rsp_bit_valid, rsp_last,
                                              rsp_all_stopped}));
   end

   // watchdog on cycles with no word moving on either channel
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("[pump_shift_register_chain_driver_unit] ERROR");
      $finish;
   end

   initial begin
      int counts [8];
      counts = '{4'd3, 4'd1, 4'd8, 4'd5, 4'd0, 4'd15, 4'd8, 4'd2};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // single module after reset, motor past the chain ignored
      send_word(OP_SHIFT, 5'd0, 2'd0);
      send_word(OP_SET, 5'd0, 2'd3);
      send_word(OP_SET, 5'd3, 2'd2);
      send_word(OP_SET, 5'd4, 2'd1);
      send_word(OP_SHIFT, 5'd31, 2'd3);
      send_word(OP_OPEN, 5'd0, 2'd0);
      send_word(OP_SET, 5'd1, 2'd0);
      send_word(OP_STOP, 5'd31, 2'd3);
      send_word(OP_SET, 5'd31, 2'd3);

      // full chain, top motors
      wait_chain_idle();
      write_count(4'd8);
      send_word(OP_SET, 5'd31, 2'd3);
      send_word(OP_SET, 5'd28, 2'd1);
      send_word(OP_SHIFT, 5'd0, 2'd0);

      // shorter chain: stop leaves the upper bytes alone
      wait_chain_idle();
      write_count(4'd2);
      send_word(OP_STOP, 5'd0, 2'd0);
      send_word(OP_SET, 5'd8, 2'd3);

      // back to full chain, the kept bytes show up again
      wait_chain_idle();
      write_count(4'd8);
      send_word(OP_SHIFT, 5'd0, 2'd0);
      send_word(OP_OPEN, 5'd0, 2'd0);
      send_word(OP_SET, 5'd17, 2'd0);

      // zero count acts as one module
      wait_chain_idle();
      write_count(4'd0);
      send_word(OP_SET, 5'd2, 2'd2);
      send_word(OP_SET, 5'd5, 2'd3);
      send_word(OP_SHIFT, 5'd0, 2'd0);

      // count above the chain length acts as the full chain
      wait_chain_idle();
      write_count(4'd15);
      send_word(OP_SET, 5'd30, 2'd2);
      send_word(OP_SHIFT, 5'd0, 2'd0);
      send_word(OP_STOP, 5'd0, 2'd0);

      // random phases, one count each, one of them without idling
      foreach (counts[p]) begin
         wait_chain_idle();
         write_count(counts[p][COUNT_W-1:0]);
         calm = (p == 2);
         repeat (ITEMS_PER_PHASE) random_word();
      end
      calm = 1'b0;

      wait_chain_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (tracker.words_due.size() != 0)
         tracker.report($sformatf("%0d response words never came", tracker.words_due.size()));
      if (tracker.errors == 0)
         $display("[pump_shift_register_chain_driver_unit] OK");
      else
         $display("[pump_shift_register_chain_driver_unit] ERROR");
      $finish;
   end

endmodule

// ===== pump_shift_register_chain_driver_unit.f =====
+incdir+hdl
hdl/pumpsr_pkg.sv
hdl/pumpsr_front.sv
hdl/pumpsr_back.sv
hdl/pump_shift_register_chain_driver_unit.sv
sim/pump_chain_tb_pkg.sv
sim/tb_top.sv
